// ===== design/thsc_pkg.sv =====
// Shared types and constants of the target heading speed controller.
package thsc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_FWD  = 2'd0,
    CFG_MAX_TURN = 2'd1,
    CFG_STOP_RAD = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_W = 12;
  localparam int unsigned FWD_W = 11;
  localparam int unsigned TURN_W = 13;
  localparam int unsigned LIM_W = 12;
  localparam int unsigned RAD_W = 12;

  localparam logic [FWD_W-1:0] MAX_FWD_RST = 11'd300;
  localparam logic [LIM_W-1:0] MAX_TURN_RST = 12'd1000;
  localparam logic [RAD_W-1:0] STOP_RAD_RST = 12'd100;

  // CORDIC setup: coordinates scaled by 2^28, angles in 2^-24 rad
  localparam int unsigned CORDIC_ITERS = 24;
  localparam int unsigned PRESCALE = 28;
  localparam int unsigned ANGLE_FRAC = 24;
  localparam int unsigned Z_W = 27;
  localparam int ATAN_TAB [CORDIC_ITERS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // Heading in mrad and table index mapping
  localparam int unsigned HEAD_W = 11;
  localparam int unsigned HEAD_SPAN = 1600;
  localparam int unsigned RECIP_W = 22;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_SPAN = 22'd2684354;  // floor(2^32 / 1600)

  // Gaussian exponent scale, 20.48/pi^2 in Q31
  localparam longint unsigned GCONST_Q31 = 64'd4456152782;
  localparam int unsigned GAUSS_W = 16;

  // Special-case flags that travel with each beat
  typedef struct packed {
    logic zero;
    logic behind;
    logic ypos;
  } flag_t;

endpackage

// ===== design/thsc_in_if.sv =====
// Target point channel: valid, ready and the target coordinates.
interface thsc_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;

  modport source (output valid, output target_x, output target_y, input ready);
  modport sink (input valid, input target_x, input target_y, output ready);
endinterface

// ===== design/thsc_out_if.sv =====
// Command channel: valid, ready and the speed and turn commands.
interface thsc_out_if;
  logic                              valid;
  logic                              ready;
  logic [thsc_pkg::FWD_W-1:0]        forward_speed;
  logic signed [thsc_pkg::TURN_W-1:0] turn_rate;

  modport source (output valid, output forward_speed, output turn_rate, input ready);
  modport sink (input valid, input forward_speed, input turn_rate, output ready);
endinterface

// ===== design/target_heading_speed_controller_top.sv =====
// Top level of the target heading speed controller pipeline.
//
// A target point (x forward, y left, mm) enters on in_i and one command beat
// (forward speed mm/s, turn rate mrad/s) leaves on out_o for each target.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; user must do so only while no target is in flight (unchecked).
// The datapath is a 32-stage pipeline: two stages of distance test, one
// register stage per CORDIC vectoring iteration (24), then heading scaling,
// turn clamp, table index reciprocal multiply, index correction, Gaussian
// table read and the final speed multiply into the output register.
// One target is accepted every cycle as long as out_o.ready stays high.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values
// (300 mm/s, 1000 mrad/s, 100 mm); the Gaussian table is a constant ROM.
module target_heading_speed_controller_top #(
  parameter int COORD_WIDTH = 16,
  parameter int GAUSS_TABLE_ENTRIES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  thsc_in_if.sink                     in_i,
  thsc_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [thsc_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int CW = COORD_WIDTH;
  localparam int CXW = COORD_WIDTH + thsc_pkg::PRESCALE + 2;
  localparam int ZW = thsc_pkg::Z_W;
  localparam int NIT = thsc_pkg::CORDIC_ITERS;
  localparam longint unsigned SPAN = longint'(GAUSS_TABLE_ENTRIES - 1);
  localparam longint unsigned SPAN_SQ = SPAN * SPAN;
  localparam int IDX_W = $clog2(GAUSS_TABLE_ENTRIES);
  localparam int NUM_W = $clog2(thsc_pkg::HEAD_SPAN * (GAUSS_TABLE_ENTRIES - 1) + 801);
  localparam int HALF_SPAN = thsc_pkg::HEAD_SPAN / 2;
  localparam int PROD_W = NUM_W + thsc_pkg::RECIP_W;
  localparam int MAG_W = ZW + 10;
  localparam int NST = NIT + 8;
  localparam int ST_F = NIT + 7;
  localparam int D2_W = (2*CW+1 > 2*thsc_pkg::RAD_W) ? 2*CW+1 : 2*thsc_pkg::RAD_W;

  // One Q0.16 Gaussian table entry, evaluated at elaboration
  function automatic logic [thsc_pkg::GAUSS_W-1:0] gauss_entry(int k);
    longint unsigned a;
    longint unsigned b;
    longint unsigned term;
    longint          sum;
    longint unsigned g;
    longint unsigned e;
    a = thsc_pkg::GCONST_Q31 * longint'(k) * longint'(k) / SPAN_SQ;
    b = a >> 2;
    term = 64'd1 << 31;
    sum = 64'sd1 <<< 31;
    // Taylor series of e^-b, alternating signs
    term = ((term * b) >> 31) / 64'd1;  sum = sum - longint'(term);
    term = ((term * b) >> 31) / 64'd2;  sum = sum + longint'(term);
    term = ((term * b) >> 31) / 64'd3;  sum = sum - longint'(term);
    term = ((term * b) >> 31) / 64'd4;  sum = sum + longint'(term);
    term = ((term * b) >> 31) / 64'd5;  sum = sum - longint'(term);
    term = ((term * b) >> 31) / 64'd6;  sum = sum + longint'(term);
    term = ((term * b) >> 31) / 64'd7;  sum = sum - longint'(term);
    term = ((term * b) >> 31) / 64'd8;  sum = sum + longint'(term);
    term = ((term * b) >> 31) / 64'd9;  sum = sum - longint'(term);
    term = ((term * b) >> 31) / 64'd10; sum = sum + longint'(term);
    term = ((term * b) >> 31) / 64'd11; sum = sum - longint'(term);
    term = ((term * b) >> 31) / 64'd12; sum = sum + longint'(term);
    term = ((term * b) >> 31) / 64'd13; sum = sum - longint'(term);
    g = (sum < 0) ? 64'd0 : longint'(sum);
    if (g > (64'd1 << 31)) g = 64'd1 << 31;
    g = (g * g) >> 31;
    g = (g * g) >> 31;
    e = (g + (64'd1 << 14)) >> 15;
    return (e > 64'd65535) ? 16'hFFFF : e[15:0];
  endfunction

  // Constant Gaussian table
  logic [thsc_pkg::GAUSS_W-1:0] gauss_rom [GAUSS_TABLE_ENTRIES];

  for (genvar k = 0; k < GAUSS_TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [thsc_pkg::GAUSS_W-1:0] ENTRY = gauss_entry(k);
    assign gauss_rom[k] = ENTRY;
  end

  // Configuration registers
  logic [thsc_pkg::FWD_W-1:0]  max_fwd_q;
  logic [thsc_pkg::LIM_W-1:0]  max_turn_q;
  logic [thsc_pkg::RAD_W-1:0]  stop_rad_q;
  logic [2*thsc_pkg::RAD_W-1:0] stop_sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fwd_q  <= thsc_pkg::MAX_FWD_RST;
      max_turn_q <= thsc_pkg::MAX_TURN_RST;
      stop_rad_q <= thsc_pkg::STOP_RAD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        thsc_pkg::CFG_MAX_FWD:  max_fwd_q  <= cfg_data_i[thsc_pkg::FWD_W-1:0];
        thsc_pkg::CFG_MAX_TURN: max_turn_q <= cfg_data_i[thsc_pkg::LIM_W-1:0];
        thsc_pkg::CFG_STOP_RAD: stop_rad_q <= cfg_data_i[thsc_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign stop_sq = stop_rad_q * stop_rad_q;

  // Pipeline control: advance all stages unless the output beat is stuck
  logic           adv;
  logic [NST-1:0] vld_q;

  assign adv = !vld_q[NST-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_i.valid};
    end
  end

  // Stage 1: capture target and square the magnitudes
  logic [CW-1:0]        ax, ay;
  logic signed [CW-1:0] x1_q, y1_q;
  logic [2*CW-1:0]      sqx_q, sqy_q;

  assign ax = in_i.target_x[CW-1] ? CW'(-in_i.target_x) : CW'(in_i.target_x);
  assign ay = in_i.target_y[CW-1] ? CW'(-in_i.target_y) : CW'(in_i.target_y);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q  <= in_i.target_x;
      y1_q  <= in_i.target_y;
      sqx_q <= ax * ax;
      sqy_q <= ay * ay;
    end
  end

  // Stage 2: distance test, special-case flags and CORDIC seed
  logic [D2_W-1:0]        d2;
  logic signed [CXW-1:0]  cx_q [NIT+1];
  logic signed [CXW-1:0]  cy_q [NIT+1];
  logic signed [ZW-1:0]   z_q  [NIT+1];
  thsc_pkg::flag_t        fl_q [NIT+1];

  assign d2 = D2_W'(sqx_q) + D2_W'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fl_q[0].zero   <= ((x1_q == '0) && (y1_q == '0)) ||
                        (d2 < D2_W'(stop_sq));
      fl_q[0].behind <= x1_q[CW-1];
      fl_q[0].ypos   <= !y1_q[CW-1];
      cx_q[0]        <= CXW'(x1_q) <<< thsc_pkg::PRESCALE;
      cy_q[0]        <= CXW'(y1_q) <<< thsc_pkg::PRESCALE;
      z_q[0]         <= '0;
    end
  end

  // CORDIC vectoring: one iteration per register stage
  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    logic signed [CXW-1:0] dx, dy;
    logic signed [ZW-1:0]  at;

    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    assign at = ZW'(thsc_pkg::ATAN_TAB[i]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        fl_q[i+1] <= fl_q[i];
        if (!cy_q[i][CXW-1]) begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          z_q[i+1]  <= z_q[i] + at;
        end else begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          z_q[i+1]  <= z_q[i] - at;
        end
      end
    end
  end

  // Heading stage: scale angle to mrad, round half away from zero
  logic [ZW-1:0]                mag;
  logic [MAG_W-1:0]             mag_mr;
  logic                         hneg_q;
  logic [thsc_pkg::HEAD_W-1:0]  hmag_q;
  thsc_pkg::flag_t              flm_q;

  assign mag = z_q[NIT][ZW-1] ? ZW'(-z_q[NIT]) : ZW'(z_q[NIT]);
  assign mag_mr = MAG_W'(mag) * MAG_W'(1000) + (MAG_W'(1) << (thsc_pkg::ANGLE_FRAC - 1));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hneg_q <= z_q[NIT][ZW-1];
      hmag_q <= mag_mr[thsc_pkg::ANGLE_FRAC +: thsc_pkg::HEAD_W];
      flm_q  <= fl_q[NIT];
    end
  end

  // Turn stage: clamp heading, pick special-case turn, form index numerator
  logic signed [thsc_pkg::TURN_W-1:0] lim_s, turn;
  logic [thsc_pkg::HEAD_W-1:0]        ah;
  logic signed [thsc_pkg::TURN_W-1:0] turn_q [4];
  logic                               kill_q [4];
  logic [NUM_W-1:0]                   num_q, num2_q;

  assign lim_s = thsc_pkg::TURN_W'(max_turn_q);

  always_comb begin
    if (flm_q.zero) begin
      turn = '0;
    end else if (flm_q.behind) begin
      turn = flm_q.ypos ? lim_s : -lim_s;
    end else if (thsc_pkg::LIM_W'(hmag_q) > max_turn_q) begin
      turn = hneg_q ? -lim_s : lim_s;
    end else begin
      turn = hneg_q ? -thsc_pkg::TURN_W'(hmag_q) : thsc_pkg::TURN_W'(hmag_q);
    end
    ah = (hmag_q > thsc_pkg::HEAD_W'(thsc_pkg::HEAD_SPAN)) ?
         thsc_pkg::HEAD_W'(thsc_pkg::HEAD_SPAN) : hmag_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      turn_q[0] <= turn;
      kill_q[0] <= flm_q.zero || flm_q.behind;
      num_q     <= NUM_W'(ah) * NUM_W'(SPAN) + NUM_W'(HALF_SPAN);
    end
  end

  // Reciprocal stage: estimate numerator / 1600
  logic [PROD_W-1:0] prod;
  logic [IDX_W:0]    q0_q;

  assign prod = PROD_W'(num_q) * PROD_W'(thsc_pkg::RECIP_SPAN);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q0_q      <= (IDX_W+1)'(prod >> thsc_pkg::RECIP_SHIFT);
      num2_q    <= num_q;
      turn_q[1] <= turn_q[0];
      kill_q[1] <= kill_q[0];
    end
  end

  // Correction stage: fix the estimate by one, clamp to the table
  logic [NUM_W-1:0] rem;
  logic [IDX_W:0]   qc;
  logic [IDX_W-1:0] idx_q;

  always_comb begin
    rem = num2_q - NUM_W'(q0_q) * NUM_W'(thsc_pkg::HEAD_SPAN);
    qc = q0_q + (IDX_W+1)'(rem >= NUM_W'(thsc_pkg::HEAD_SPAN));
    if (qc > (IDX_W+1)'(GAUSS_TABLE_ENTRIES - 1)) qc = (IDX_W+1)'(GAUSS_TABLE_ENTRIES - 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx_q     <= qc[IDX_W-1:0];
      turn_q[2] <= turn_q[1];
      kill_q[2] <= kill_q[1];
    end
  end

  // Table stage: read the Gaussian entry
  logic [thsc_pkg::GAUSS_W-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      entry_q   <= gauss_rom[idx_q];
      turn_q[3] <= turn_q[2];
      kill_q[3] <= kill_q[2];
    end
  end

  // Output stage: scale the maximum speed, drop it for special cases
  logic [thsc_pkg::FWD_W+thsc_pkg::GAUSS_W:0] fprod;
  logic [thsc_pkg::FWD_W-1:0]                 fwd_q;
  logic signed [thsc_pkg::TURN_W-1:0]         turn_o_q;

  localparam int FP_W = thsc_pkg::FWD_W + thsc_pkg::GAUSS_W + 1;

  assign fprod = FP_W'(max_fwd_q) * FP_W'(entry_q) + (FP_W'(1) << 15);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_q    <= kill_q[3] ? '0 : fprod[16 +: thsc_pkg::FWD_W];
      turn_o_q <= turn_q[3];
    end
  end

  assign out_o.valid         = vld_q[ST_F];
  assign out_o.forward_speed = fwd_q;
  assign out_o.turn_rate     = turn_o_q;

endmodule

// ===== test/target_heading_speed_controller_top_tb.sv =====
// Testbench of the target heading speed controller: table and random targets against a predictor.
module target_heading_speed_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAUSS_N = 256;
  localparam int WATCHDOG = 20000;
  localparam int LATENCY = 32;
  localparam int CFGW = thsc_pkg::CFG_W;

  typedef struct packed {
    logic [thsc_pkg::FWD_W-1:0]         fwd;
    logic signed [thsc_pkg::TURN_W-1:0] turn;
  } cmd_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               known;
    cmd_t               cmd;
  } target_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFGW-1:0] cfg_data_i = '0;

  thsc_in_if #(.COORD_WIDTH(16)) in_ch ();
  thsc_out_if out_ch ();

  target_heading_speed_controller_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: register copies and the Gaussian table
  logic [thsc_pkg::FWD_W-1:0] max_fwd = thsc_pkg::MAX_FWD_RST;
  logic [thsc_pkg::LIM_W-1:0] max_turn = thsc_pkg::MAX_TURN_RST;
  logic [thsc_pkg::RAD_W-1:0] stop_rad = thsc_pkg::STOP_RAD_RST;
  logic [15:0] gauss_tab [GAUSS_N];
  cmd_t pending_cmds [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_ready = 1'b0;

  initial begin
    longint unsigned a, b, term, g, e, span;
    longint sum;
    span = GAUSS_N - 1;
    for (int k = 0; k < GAUSS_N; k++) begin
      a = thsc_pkg::GCONST_Q31 * longint'(k) * longint'(k) / (span * span);
      b = a >> 2;
      term = 64'd1 << 31;
      sum = 64'sd1 << 31;
      for (int n = 1; n <= 13; n++) begin
        term = ((term * b) >> 31) / n;
        if (n % 2) sum -= longint'(term);
        else sum += longint'(term);
      end
      g = (sum < 0) ? 0 : longint'(sum);
      if (g > (64'd1 << 31)) g = 64'd1 << 31;
      g = (g * g) >> 31;
      g = (g * g) >> 31;
      e = (g + (64'd1 << 14)) >> 15;
      gauss_tab[k] = (e > 65535) ? 16'hFFFF : e[15:0];
    end
  end

  // Heading in mrad by vectoring CORDIC, for x >= 0
  function automatic longint heading_of(longint x, longint y);
    longint cx, cy, z, dx, dy, hm;
    longint unsigned mag;
    cx = x <<< thsc_pkg::PRESCALE;
    cy = y <<< thsc_pkg::PRESCALE;
    z = 0;
    for (int i = 0; i < thsc_pkg::CORDIC_ITERS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += thsc_pkg::ATAN_TAB[i];
      end else begin
        cx -= dx; cy += dy; z -= thsc_pkg::ATAN_TAB[i];
      end
    end
    mag = (z < 0) ? -z : z;
    hm = longint'((mag * 1000 + (64'd1 << (thsc_pkg::ANGLE_FRAC - 1))) >>
                  thsc_pkg::ANGLE_FRAC);
    return (z < 0) ? -hm : hm;
  endfunction

  function automatic cmd_t steer_cmd(logic signed [15:0] tx, logic signed [15:0] ty);
    longint x, y, d2, lim, h, ah, idx, turn;
    longint unsigned fwd;
    cmd_t c;
    x = tx;
    y = ty;
    d2 = x * x + y * y;
    lim = max_turn;
    fwd = 0;
    turn = 0;
    if ((x == 0 && y == 0) || d2 < longint'(stop_rad) * longint'(stop_rad)) begin
      turn = 0;
    end else if (x < 0) begin
      turn = (y >= 0) ? lim : -lim;
    end else begin
      h = heading_of(x, y);
      ah = (h < 0) ? -h : h;
      turn = (h > lim) ? lim : ((h < -lim) ? -lim : h);
      if (ah > thsc_pkg::HEAD_SPAN) ah = thsc_pkg::HEAD_SPAN;
      idx = (ah * (GAUSS_N - 1) + thsc_pkg::HEAD_SPAN / 2) / thsc_pkg::HEAD_SPAN;
      if (idx >= GAUSS_N) idx = GAUSS_N - 1;
      fwd = (longint'(max_fwd) * gauss_tab[idx] + 32768) >> 16;
    end
    c.fwd = fwd[thsc_pkg::FWD_W-1:0];
    c.turn = turn[thsc_pkg::TURN_W-1:0];
    return c;
  endfunction

  // Check each accepted command beat against the oldest expectation
  always @(posedge clk_i) begin
    cmd_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected beat fwd=%0d turn=%0d", $time, out_ch.forward_speed,
                 out_ch.turn_rate);
        errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_ch.forward_speed !== want.fwd) begin
          $display("%0t: forward_speed expected %0d actual %0d", $time, want.fwd,
                   out_ch.forward_speed);
          errors++;
        end
        if (out_ch.turn_rate !== want.turn) begin
          $display("%0t: turn_rate expected %0d actual %0d", $time, want.turn,
                   out_ch.turn_rate);
          errors++;
        end
      end
    end
  end

  // Randomly stall the receiver: mostly short gaps, a few long ones
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!stall_ready) begin
        out_ch.ready <= 1'b1;
      end else begin
        n = $urandom_range(0, 9);
        if (n < 5) out_ch.ready <= 1'b1;
        else begin
          out_ch.ready <= 1'b0;
          n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
          repeat (n - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("target_heading_speed_controller_top_tb: errors");
      $finish;
    end
  end

  // Write one register, then drop the write enable before returning
  task automatic write_reg(thsc_pkg::cfg_idx_e idx, logic [CFGW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      thsc_pkg::CFG_MAX_FWD:  max_fwd = val[thsc_pkg::FWD_W-1:0];
      thsc_pkg::CFG_MAX_TURN: max_turn = val[thsc_pkg::LIM_W-1:0];
      thsc_pkg::CFG_STOP_RAD: stop_rad = val[thsc_pkg::RAD_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Send one target beat, hold until accepted, then maybe idle
  task automatic send_target(logic signed [15:0] x, logic signed [15:0] y, bit gaps);
    int n;
    in_ch.valid <= 1'b1;
    in_ch.target_x <= x;
    in_ch.target_y <= y;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_cmds = {pending_cmds, steer_cmd(x, y)};
    if (gaps && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [15:0] rand_coord(int lim);
    int v;
    v = $urandom_range(0, 2 * lim) - lim;
    return v[15:0];
  endfunction

  initial begin
    target_row_t rows [$];
    target_row_t r;
    cmd_t want;
    int mode, lim;
    in_ch.valid = 1'b0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: x, y, known, expected (fwd, turn), reset registers
    rows = '{
      '{16'sd0, 16'sd0, 1'b1, '{11'd0, 13'sd0}},
      '{16'sd60, 16'sd60, 1'b1, '{11'd0, 13'sd0}},
      '{16'sd99, 16'sd0, 1'b1, '{11'd0, 13'sd0}},
      '{16'sd100, 16'sd0, 1'b1, '{11'd300, 13'sd0}},
      '{-16'sd1000, 16'sd0, 1'b1, '{11'd0, 13'sd1000}},
      '{-16'sd1000, -16'sd5, 1'b1, '{11'd0, -13'sd1000}},
      '{-16'sd32768, -16'sd32768, 1'b1, '{11'd0, -13'sd1000}},
      '{-16'sd32768, 16'sd32767, 1'b1, '{11'd0, 13'sd1000}},
      '{16'sd32767, 16'sd0, 1'b1, '{11'd300, 13'sd0}},
      '{16'sd0, 16'sd500, 1'b0, '{11'd0, 13'sd0}},
      '{16'sd0, -16'sd500, 1'b0, '{11'd0, 13'sd0}},
      '{16'sd0, -16'sd32768, 1'b0, '{11'd0, 13'sd0}},
      '{16'sd32767, 16'sd32767, 1'b0, '{11'd0, 13'sd0}},
      '{16'sd32767, -16'sd32768, 1'b0, '{11'd0, 13'sd0}},
      '{16'sd1000, 16'sd300, 1'b0, '{11'd0, 13'sd0}},
      '{16'sd1, 16'sd32767, 1'b0, '{11'd0, 13'sd0}}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_target(r.x, r.y, 1'b0);
      if (r.known) begin
        want = pending_cmds[$];
        if (want !== r.cmd) begin
          $display("%0t: table row %0d expected %h predictor %h", $time, i, r.cmd, want);
          errors++;
        end
      end
    end
    drain_and_settle();

    // Extreme settings, then random ones
    write_reg(thsc_pkg::CFG_MAX_FWD, 12'd2000);
    write_reg(thsc_pkg::CFG_MAX_TURN, 12'd4000);
    write_reg(thsc_pkg::CFG_STOP_RAD, 12'd0);
    send_target(16'sd0, 16'sd0, 1'b0);
    send_target(16'sd0, 16'sd1, 1'b0);
    send_target(-16'sd1, 16'sd0, 1'b0);
    send_target(16'sd5, -16'sd32768, 1'b0);
    drain_and_settle();
    write_reg(thsc_pkg::CFG_STOP_RAD, 12'hFFF);
    send_target(16'sd2895, 16'sd2895, 1'b0);
    send_target(16'sd4095, 16'sd0, 1'b0);
    stall_ready = 1'b1;

    for (int phase = 0; phase < 8; phase++) begin
      drain_and_settle();
      case (phase)
        0: begin
          write_reg(thsc_pkg::CFG_MAX_FWD, 12'd0);
          write_reg(thsc_pkg::CFG_MAX_TURN, 12'd0);
          write_reg(thsc_pkg::CFG_STOP_RAD, 12'd0);
        end
        1: begin
          write_reg(thsc_pkg::CFG_MAX_FWD, 12'hFFF);
          write_reg(thsc_pkg::CFG_MAX_TURN, 12'hFFF);
          write_reg(thsc_pkg::CFG_STOP_RAD, 12'd50);
        end
        2: begin
          write_reg(thsc_pkg::CFG_MAX_FWD, 12'h7FF);
          write_reg(thsc_pkg::CFG_MAX_TURN, 12'd1);
          write_reg(thsc_pkg::CFG_STOP_RAD, 12'hAAA);
        end
        default: begin
          write_reg(thsc_pkg::CFG_MAX_FWD, CFGW'($urandom_range(0, 2047)));
          write_reg(thsc_pkg::CFG_MAX_TURN, CFGW'($urandom_range(0, 4095)));
          write_reg(thsc_pkg::CFG_STOP_RAD, CFGW'($urandom_range(0, 600)));
        end
      endcase
      for (int k = 0; k < 155; k++) begin
        mode = $urandom_range(0, 9);
        lim = (mode < 4) ? 3000 : ((mode < 6) ? 200 : 32767);
        if (mode == 9) send_target(16'($urandom), 16'($urandom), 1'b1);
        else if (mode == 8) send_target(16'($urandom_range(0, 32767)), 16'($urandom), 1'b1);
        else send_target(rand_coord(lim), rand_coord(lim), 1'b1);
      end
    end

    drain_and_settle();
    if (errors == 0) $display("target_heading_speed_controller_top_tb: clean");
    else $display("target_heading_speed_controller_top_tb: errors");
    $finish;
  end
endmodule
